FILE: rtl/bitk_pkg.sv
// ----------------------------------------------------------------------------
// bitk_pkg
// shared types and constants of the bone influence store
// ----------------------------------------------------------------------------
package bitk_pkg;

  localparam int unsigned BONE_W    = 8;
  localparam int unsigned WEIGHT_W  = 16;
  localparam int unsigned FRAC_W    = 15;
  localparam int unsigned SUM_W     = 19;
  localparam int unsigned QUOT_W    = 16;
  localparam int unsigned NUM_W     = 32;
  localparam int unsigned OUT_SLOTS = 4;
  localparam int unsigned VCOUNT_W  = 13;
  localparam int unsigned VIDX_W    = 16;
  localparam int unsigned CFG_W     = 16;

  localparam logic [BONE_W-1:0] EMPTY_BONE = 8'hFF;
  localparam logic [SUM_W-1:0]  ONE_Q15    = 19'd32768;

  localparam logic [0:0] CFG_VERTEX_COUNT = 1'b0;
  localparam logic [0:0] CFG_NORM_TOL     = 1'b1;

  typedef enum logic [1:0] {
    REQ_CLEAR = 2'd0,
    REQ_ADD   = 2'd1,
    REQ_NORM  = 2'd2,
    REQ_RSVD  = 2'd3
  } req_e;

  typedef enum logic [3:0] {
    ST_STORED     = 4'd0,
    ST_REPLACED   = 4'd1,
    ST_DROPPED    = 4'd2,
    ST_BAD_BONE   = 4'd3,
    ST_BAD_VERTEX = 4'd4,
    ST_NORMALIZED = 4'd5,
    ST_UNCHANGED  = 4'd6,
    ST_NO_BONES   = 4'd7,
    ST_CLEARED    = 4'd8
  } status_e;

endpackage

FILE: rtl/bitk_ram.sv
// ----------------------------------------------------------------------------
// bitk_ram
// single port synchronous ram with registered read
// ----------------------------------------------------------------------------
module bitk_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

FILE: rtl/bitk_div.sv
// ----------------------------------------------------------------------------
// bitk_div
// restoring divider, one quotient bit per cycle, quotient known to fit
// ----------------------------------------------------------------------------
module bitk_div import bitk_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [NUM_W-1:0]  num_i,
  input  logic [SUM_W-1:0]  den_i,
  output logic              done_o,
  output logic [QUOT_W-1:0] quot_o
);

  localparam int unsigned CNT_W = $clog2(QUOT_W);

  logic [SUM_W-1:0]  rem_q, rem_d;
  logic [SUM_W-1:0]  den_q, den_d;
  logic [QUOT_W-1:0] low_q, low_d;
  logic [QUOT_W-1:0] quot_q, quot_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              run_q, run_d;
  logic              done_q, done_d;
  logic [SUM_W:0]    trial;
  logic [SUM_W+1:0]  diff;

  always_comb begin
    trial  = {rem_q, low_q[QUOT_W-1]};
    diff   = {1'b0, trial} - {2'b00, den_q};
    rem_d  = rem_q;
    den_d  = den_q;
    low_d  = low_q;
    quot_d = quot_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d = SUM_W'(num_i[NUM_W-1:QUOT_W]);
      low_d = num_i[QUOT_W-1:0];
      den_d = den_i;
      cnt_d = '0;
      run_d = 1'b1;
    end else if (run_q) begin
      rem_d  = diff[SUM_W+1] ? trial[SUM_W-1:0] : diff[SUM_W-1:0];
      low_d  = {low_q[QUOT_W-2:0], 1'b0};
      quot_d = {quot_q[QUOT_W-2:0], ~diff[SUM_W+1]};
      cnt_d  = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(QUOT_W - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      run_q  <= run_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    den_q  <= den_d;
    low_q  <= low_d;
    quot_q <= quot_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

FILE: rtl/bone_influence_topk_store.sv
// ----------------------------------------------------------------------------
// bone_influence_topk_store
// per-vertex bone influence slots with add, clear and normalize requests
// ----------------------------------------------------------------------------
// One request at a time; busy is high while one is in flight and the result
// is shown on done_o for one cycle, which the receiver must take. Clear and
// bad-vertex requests are answered from idle; add, reserved and normalize
// requests first read the vertex row from the slot rams, and an add that stores
// writes it back. A normalize that rescales divides each active slot weight
// in turn on the shared divider (one quotient bit per cycle) and then writes
// the row back. A vertex must be cleared before any other request reads it.
module bone_influence_topk_store import bitk_pkg::*; #(
  parameter int unsigned VERTICES = 4096,
  parameter int unsigned SLOTS    = 4,
  parameter int unsigned BONES    = 128
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  output logic                       done_o,
  input  logic                       cfg_we_i,
  input  logic [0:0]                 cfg_index_i,
  input  logic [CFG_W-1:0]           cfg_data_i,
  input  logic [1:0]                 req_type_i,
  input  logic [VIDX_W-1:0]          vertex_index_i,
  input  logic [BONE_W-1:0]          bone_id_i,
  input  logic [WEIGHT_W-1:0]        weight_i,
  output logic [3:0]                 status_o,
  output logic [VIDX_W-1:0]          out_vertex_o,
  output logic signed [BONE_W-1:0]   slot0_bone_o,
  output logic signed [BONE_W-1:0]   slot1_bone_o,
  output logic signed [BONE_W-1:0]   slot2_bone_o,
  output logic signed [BONE_W-1:0]   slot3_bone_o,
  output logic [WEIGHT_W-1:0]        slot0_weight_o,
  output logic [WEIGHT_W-1:0]        slot1_weight_o,
  output logic [WEIGHT_W-1:0]        slot2_weight_o,
  output logic [WEIGHT_W-1:0]        slot3_weight_o
);

  localparam int unsigned ADDR_W = (VERTICES > 1) ? $clog2(VERTICES) : 1;
  localparam int unsigned IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned PAD_N  = (SLOTS > OUT_SLOTS) ? SLOTS : OUT_SLOTS;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_NEXT = 3'd2;
  localparam logic [2:0] S_WAIT = 3'd3;
  localparam logic [2:0] S_WB   = 3'd4;

  logic [2:0]                             state_q, state_d;
  req_e                                   req_q, req_d;
  logic [VIDX_W-1:0]                      vtx_q, vtx_d;
  logic [BONE_W-1:0]                      bone_q, bone_d;
  logic [WEIGHT_W-1:0]                    wt_in_q, wt_in_d;
  logic [VCOUNT_W-1:0]                    vertex_count_q;
  logic [WEIGHT_W-1:0]                    norm_tol_q;

  logic [SLOTS-1:0][BONE_W-1:0]           row_bone_q, row_bone_d;
  logic [SLOTS-1:0][WEIGHT_W-1:0]         row_wt_q, row_wt_d;
  logic [SLOTS-1:0]                       act_q, act_d;
  logic [SUM_W-1:0]                       sum_q, sum_d;
  logic [IDX_W-1:0]                       idx_q, idx_d;

  logic                                   done_q, done_d;
  status_e                                status_q, status_d;
  logic [VIDX_W-1:0]                      out_vertex_q, out_vertex_d;
  logic [OUT_SLOTS-1:0][BONE_W-1:0]       out_bone_q, out_bone_d;
  logic [OUT_SLOTS-1:0][WEIGHT_W-1:0]     out_wt_q, out_wt_d;

  logic [SLOTS-1:0][BONE_W-1:0]           rd_bone, bone_wdata, emit_bone;
  logic [SLOTS-1:0][WEIGHT_W-1:0]         rd_wt, wt_wdata, emit_wt;
  logic [PAD_N-1:0][BONE_W-1:0]           pad_bone;
  logic [PAD_N-1:0][WEIGHT_W-1:0]         pad_wt;
  logic [ADDR_W-1:0]                      ram_addr;
  logic                                   bone_we, wt_we;
  logic                                   accept, vtx_bad, bone_bad;
  logic                                   emit, emit_blank;
  status_e                                emit_status;
  logic                                   found, do_write;
  logic [IDX_W-1:0]                       fidx, midx, tidx;
  logic [WEIGHT_W-1:0]                    mval;
  logic [SLOTS-1:0]                       rd_act;
  logic [SUM_W-1:0]                       rd_sum, sum_diff;
  logic                                   last_idx;
  logic                                   div_start, div_done;
  logic [NUM_W-1:0]                       div_num;
  logic [QUOT_W-1:0]                      div_quot;

  assign busy     = (state_q != S_IDLE);
  assign accept   = start && !busy;
  assign vtx_bad  = ({1'b0, vertex_index_i} >= {4'b0000, vertex_count_q})
                 || ({1'b0, vertex_index_i} >= (VIDX_W + 1)'(VERTICES));
  assign bone_bad = ({1'b0, bone_q} >= (BONE_W + 1)'(BONES));
  assign ram_addr = busy ? vtx_q[ADDR_W-1:0] : vertex_index_i[ADDR_W-1:0];
  assign last_idx = (idx_q == IDX_W'(SLOTS - 1));
  assign div_num  = (NUM_W'(row_wt_q[idx_q]) << FRAC_W) + NUM_W'(sum_q[SUM_W-1:1]);

  bitk_ram #(
    .WIDTH (SLOTS * BONE_W),
    .DEPTH (VERTICES)
  ) u_bone_ram (
    .clk_i   (clk_i),
    .we_i    (bone_we),
    .addr_i  (ram_addr),
    .wdata_i (bone_wdata),
    .rdata_o (rd_bone)
  );

  bitk_ram #(
    .WIDTH (SLOTS * WEIGHT_W),
    .DEPTH (VERTICES)
  ) u_weight_ram (
    .clk_i   (clk_i),
    .we_i    (wt_we),
    .addr_i  (ram_addr),
    .wdata_i (wt_wdata),
    .rdata_o (rd_wt)
  );

  bitk_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (sum_q),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // slot search and weight sum over the row just read
  always_comb begin
    found  = 1'b0;
    fidx   = '0;
    midx   = '0;
    mval   = rd_wt[0];
    rd_sum = '0;
    for (int s = SLOTS - 1; s >= 0; s--) begin
      if (rd_bone[s][BONE_W-1]) begin
        found = 1'b1;
        fidx  = IDX_W'(s);
      end
    end
    for (int s = 1; s < SLOTS; s++) begin
      if (rd_wt[s] < mval) begin
        mval = rd_wt[s];
        midx = IDX_W'(s);
      end
    end
    for (int s = 0; s < SLOTS; s++) begin
      rd_act[s] = !rd_bone[s][BONE_W-1] && (rd_wt[s] != '0);
      rd_sum    = rd_sum + (rd_act[s] ? SUM_W'(rd_wt[s]) : '0);
    end
    sum_diff = (rd_sum >= ONE_Q15) ? (rd_sum - ONE_Q15) : (ONE_Q15 - rd_sum);
    do_write = found || (wt_in_q > mval);
    tidx     = found ? fidx : midx;
  end

  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    vtx_d       = vtx_q;
    bone_d      = bone_q;
    wt_in_d     = wt_in_q;
    row_bone_d  = row_bone_q;
    row_wt_d    = row_wt_q;
    act_d       = act_q;
    sum_d       = sum_q;
    idx_d       = idx_q;
    bone_we     = 1'b0;
    wt_we       = 1'b0;
    bone_wdata  = rd_bone;
    wt_wdata    = rd_wt;
    emit        = 1'b0;
    emit_blank  = 1'b0;
    emit_status = ST_UNCHANGED;
    emit_bone   = rd_bone;
    emit_wt     = rd_wt;
    div_start   = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          req_d   = req_e'(req_type_i);
          vtx_d   = vertex_index_i;
          bone_d  = bone_id_i;
          wt_in_d = weight_i;
          if (vtx_bad) begin
            emit        = 1'b1;
            emit_blank  = 1'b1;
            emit_status = ST_BAD_VERTEX;
          end else if (req_e'(req_type_i) == REQ_CLEAR) begin
            bone_we     = 1'b1;
            wt_we       = 1'b1;
            bone_wdata  = {SLOTS{EMPTY_BONE}};
            wt_wdata    = '0;
            emit        = 1'b1;
            emit_status = ST_CLEARED;
            emit_bone   = {SLOTS{EMPTY_BONE}};
            emit_wt     = '0;
          end else begin
            state_d = S_READ;
          end
        end
      end
      S_READ: begin
        state_d = S_IDLE;
        emit    = 1'b1;
        unique case (req_q)
          REQ_ADD: begin
            if (bone_bad) begin
              emit_status = ST_BAD_BONE;
            end else begin
              bone_wdata[tidx] = bone_q;
              wt_wdata[tidx]   = wt_in_q;
              bone_we          = do_write;
              wt_we            = do_write;
              if (do_write) begin
                emit_bone = bone_wdata;
                emit_wt   = wt_wdata;
              end
              emit_status = found ? ST_STORED : (do_write ? ST_REPLACED : ST_DROPPED);
            end
          end
          REQ_NORM: begin
            if (rd_act == '0) begin
              emit_status = ST_NO_BONES;
            end else if (sum_diff > SUM_W'(norm_tol_q)) begin
              emit       = 1'b0;
              row_bone_d = rd_bone;
              row_wt_d   = rd_wt;
              act_d      = rd_act;
              sum_d      = rd_sum;
              idx_d      = '0;
              state_d    = S_NEXT;
            end else begin
              emit_status = ST_UNCHANGED;
            end
          end
          default: begin
            emit_status = ST_UNCHANGED;
          end
        endcase
      end
      S_NEXT: begin
        if (act_q[idx_q]) begin
          div_start = 1'b1;
          state_d   = S_WAIT;
        end else if (last_idx) begin
          state_d = S_WB;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      S_WAIT: begin
        if (div_done) begin
          row_wt_d[idx_q] = div_quot;
          if (last_idx) begin
            state_d = S_WB;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = S_NEXT;
          end
        end
      end
      S_WB: begin
        wt_we       = 1'b1;
        wt_wdata    = row_wt_q;
        emit        = 1'b1;
        emit_status = ST_NORMALIZED;
        emit_bone   = row_bone_q;
        emit_wt     = row_wt_q;
        state_d     = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // result registers, slots past the configured count read as empty
  always_comb begin
    pad_bone = {PAD_N{EMPTY_BONE}};
    pad_wt   = '0;
    for (int s = 0; s < SLOTS; s++) begin
      pad_bone[s] = emit_bone[s];
      pad_wt[s]   = emit_wt[s];
    end
    done_d       = emit;
    status_d     = status_q;
    out_vertex_d = out_vertex_q;
    out_bone_d   = out_bone_q;
    out_wt_d     = out_wt_q;
    if (emit) begin
      status_d     = emit_status;
      out_vertex_d = busy ? vtx_q : vertex_index_i;
      for (int s = 0; s < OUT_SLOTS; s++) begin
        out_bone_d[s] = emit_blank ? '0 : pad_bone[s];
        out_wt_d[s]   = emit_blank ? '0 : pad_wt[s];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      done_q         <= 1'b0;
      vertex_count_q <= VCOUNT_W'(4096);
      norm_tol_q     <= WEIGHT_W'(33);
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_VERTEX_COUNT: vertex_count_q <= cfg_data_i[VCOUNT_W-1:0];
          CFG_NORM_TOL:     norm_tol_q     <= cfg_data_i[WEIGHT_W-1:0];
          default:          norm_tol_q     <= norm_tol_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    req_q        <= req_d;
    vtx_q        <= vtx_d;
    bone_q       <= bone_d;
    wt_in_q      <= wt_in_d;
    row_bone_q   <= row_bone_d;
    row_wt_q     <= row_wt_d;
    act_q        <= act_d;
    sum_q        <= sum_d;
    idx_q        <= idx_d;
    status_q     <= status_d;
    out_vertex_q <= out_vertex_d;
    out_bone_q   <= out_bone_d;
    out_wt_q     <= out_wt_d;
  end

  assign done_o         = done_q;
  assign status_o       = status_q;
  assign out_vertex_o   = out_vertex_q;
  assign slot0_bone_o   = $signed(out_bone_q[0]);
  assign slot1_bone_o   = $signed(out_bone_q[1]);
  assign slot2_bone_o   = $signed(out_bone_q[2]);
  assign slot3_bone_o   = $signed(out_bone_q[3]);
  assign slot0_weight_o = out_wt_q[0];
  assign slot1_weight_o = out_wt_q[1];
  assign slot2_weight_o = out_wt_q[2];
  assign slot3_weight_o = out_wt_q[3];

endmodule
